### hw/rtl/bdm_pkg.sv
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types and frame geometry for the GBRG bilinear demosaic core.
// ----------------------------------------------------------------------------
package bdm_pkg;

  // Frame geometry
  localparam int IMG_WIDTH  = 1024;
  localparam int IMG_HEIGHT = 1024;
  localparam int FRAME_SIZE = IMG_WIDTH * IMG_HEIGHT;

  localparam int COL_W = $clog2(IMG_WIDTH);
  localparam int ROW_W = $clog2(IMG_HEIGHT);
  localparam int CNT_W = $clog2(FRAME_SIZE + 1);

  localparam int PIX_W = 8;

  // Kind of an input transaction, carried on tuser
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  // Per-pixel control carried from the input stage to the window stage
  typedef struct packed {
    logic emit;
    logic frame_end;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic row_odd;
    logic col_odd;
  } s1_ctl_t;

endpackage

### hw/rtl/bilinear_demosaic_gbrg_core.sv
// ----------------------------------------------------------------------------
// bilinear_demosaic_gbrg_core
// Streaming bilinear demosaic of a GBRG Bayer frame, one RGB pixel per sample.
// ----------------------------------------------------------------------------
// Raw 8-bit samples of an IMG_WIDTH x IMG_HEIGHT GBRG frame enter in raster
// order on the slave stream with tuser low; even rows carry G,B,G,B and odd
// rows R,G,R,G. Every pixel leaves in raster order on the master stream as
// red/green/blue, with tlast on the final pixel of the frame. A pixel needs
// the row below it, so sample k produces the pixel at position k-(W+1); once
// the whole frame is in, send W+1 transactions with tuser high (drain ticks)
// to flush the remaining pixels, one each. Drain ticks that arrive before the
// frame is complete, and samples that arrive after it and before the flush
// ends, are accepted and dropped without a result. Missing colours are the
// truncating mean of the two (green site) or four (red/blue site) nearest
// neighbours of that colour; neighbours outside the frame count as zero.
// The core takes one transaction per clock, sustained while the output
// does not stall. An accepted sample lands in the input register, and its
// pixel then moves into the output register unless that register is still
// held by an unaccepted pixel. Rate is set by a single pass through two
// line memories (one sample written and one read per memory per cycle) and
// a 3x3 window register. Line memory contents need no clearing after reset:
// every neighbour that was not written in the current frame lies outside
// the frame and is masked to zero.
// After reset the core is ready at once and starts a new frame.
// ----------------------------------------------------------------------------
module bilinear_demosaic_gbrg_core (
  input  logic                     clk,
  input  logic                     rst,
  // slave stream: raw samples and drain ticks
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] raw_sample
  input  logic                     s_axis_tuser,   // [0] op (0 sample, 1 drain)
  // master stream: RGB pixels
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [7:0] red, [15:8] green,
                                                   // [23:16] blue
  output logic                     m_axis_tlast    // frame_end
);
  import bdm_pkg::*;

  // --------------------------------------------------------------------------
  // Input side control
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] in_cnt;     // samples taken in the current frame
  logic [COL_W-1:0] out_col;    // position of the next pixel to leave
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] wr_addr;    // line memory pointer, advances on every shift

  logic in_acc;
  logic is_sample;
  logic is_drain;
  logic frame_in;               // all samples of the frame are in
  logic shift;                  // transaction moves the window
  logic emit;                   // transaction produces a pixel
  logic load;
  logic last_pix;

  logic       s1_valid;
  logic       s1_adv;
  s1_ctl_t    s1_ctl;
  logic [7:0] s1_bot;           // x[k]
  logic [7:0] s1_mid;           // x[k-W], read from line A
  logic [7:0] s1_top;           // x[k-2W], read from line B
  logic [COL_W-1:0] s1_addr;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign is_sample = (op_t'(s_axis_tuser) == OP_SAMPLE);
  assign is_drain  = (op_t'(s_axis_tuser) == OP_DRAIN);
  assign frame_in  = (in_cnt == CNT_W'(FRAME_SIZE));

  // A sample past the end of the frame and an early drain tick do nothing.
  assign shift = (is_sample && !frame_in) || (is_drain && frame_in);
  assign emit  = (is_sample && !frame_in && (in_cnt >= CNT_W'(IMG_WIDTH + 1)))
              || (is_drain && frame_in);
  assign load  = in_acc && shift;

  assign last_pix = (out_row == ROW_W'(IMG_HEIGHT - 1)) &&
                    (out_col == COL_W'(IMG_WIDTH - 1));

  // Hold the input while the window stage is full and cannot move on.
  assign s1_adv        = s1_valid && (!s1_ctl.emit || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      out_col <= '0;
      out_row <= '0;
      wr_addr <= '0;
    end else if (load) begin
      if (wr_addr == COL_W'(IMG_WIDTH - 1)) begin
        wr_addr <= '0;
      end else begin
        wr_addr <= wr_addr + 1'b1;
      end
      if (is_sample) begin
        in_cnt <= in_cnt + 1'b1;
      end
      if (emit) begin
        if (out_col == COL_W'(IMG_WIDTH - 1)) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
        // Final pixel of the frame: wrap both sides for the next frame.
        if (last_pix) begin
          out_col <= '0;
          out_row <= '0;
          in_cnt  <= '0;
        end
      end
    end
  end

  // Stage 1 register: sample, pixel control and line memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_bot             <= is_sample ? s_axis_tdata : 8'd0;
      s1_addr            <= wr_addr;
      s1_ctl.emit        <= emit;
      s1_ctl.frame_end   <= last_pix;
      s1_ctl.top_ok      <= (out_row != '0);
      s1_ctl.bot_ok      <= (out_row != ROW_W'(IMG_HEIGHT - 1));
      s1_ctl.left_ok     <= (out_col != '0);
      s1_ctl.right_ok    <= (out_col != COL_W'(IMG_WIDTH - 1));
      s1_ctl.row_odd     <= out_row[0];
      s1_ctl.col_odd     <= out_col[0];
    end
  end

  // --------------------------------------------------------------------------
  // Line memories: each delays the stream by one line (W shifts).
  // Line A is written and read at the same address; the old word is x[k-W].
  // Line B is written one stage later with x[k-W] and read at shift time.
  // --------------------------------------------------------------------------
  logic [7:0] line_a [IMG_WIDTH];
  logic [7:0] line_b [IMG_WIDTH];

  always_ff @(posedge clk) begin
    if (load) begin
      line_a[wr_addr] <= is_sample ? s_axis_tdata : 8'd0;
      s1_mid          <= line_a[wr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_top <= line_b[wr_addr];
    end
    if (s1_adv) begin
      line_b[s1_addr] <= s1_mid;
    end
  end

  // --------------------------------------------------------------------------
  // 3x3 window: index (dr+1)*3 + (dc+1); the new column enters on the right.
  // --------------------------------------------------------------------------
  logic [7:0] win      [9];
  logic [7:0] win_next [9];
  logic [7:0] nb       [9];   // window with out-of-frame neighbours zeroed

  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = s1_top;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = s1_mid;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_bot;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win <= win_next;
    end
  end

  always_comb begin
    nb[0] = (s1_ctl.top_ok && s1_ctl.left_ok)  ? win_next[0] : 8'd0;
    nb[1] =  s1_ctl.top_ok                     ? win_next[1] : 8'd0;
    nb[2] = (s1_ctl.top_ok && s1_ctl.right_ok) ? win_next[2] : 8'd0;
    nb[3] =  s1_ctl.left_ok                    ? win_next[3] : 8'd0;
    nb[4] =  win_next[4];
    nb[5] =  s1_ctl.right_ok                   ? win_next[5] : 8'd0;
    nb[6] = (s1_ctl.bot_ok && s1_ctl.left_ok)  ? win_next[6] : 8'd0;
    nb[7] =  s1_ctl.bot_ok                     ? win_next[7] : 8'd0;
    nb[8] = (s1_ctl.bot_ok && s1_ctl.right_ok) ? win_next[8] : 8'd0;
  end

  // --------------------------------------------------------------------------
  // Interpolation
  // --------------------------------------------------------------------------
  logic [8:0] horz;
  logic [8:0] vert;
  logic [9:0] orth;
  logic [9:0] diag;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign horz = {1'b0, nb[3]} + {1'b0, nb[5]};
  assign vert = {1'b0, nb[1]} + {1'b0, nb[7]};
  assign orth = {1'b0, horz} + {1'b0, vert};
  assign diag = ({2'b00, nb[0]} + {2'b00, nb[2]}) + ({2'b00, nb[6]} + {2'b00, nb[8]});

  always_comb begin
    unique case ({s1_ctl.row_odd, s1_ctl.col_odd})
      2'b00: begin   // green between blues
        green = nb[4];
        blue  = horz[8:1];
        red   = vert[8:1];
      end
      2'b01: begin   // blue site
        blue  = nb[4];
        green = orth[9:2];
        red   = diag[9:2];
      end
      2'b10: begin   // red site
        red   = nb[4];
        green = orth[9:2];
        blue  = diag[9:2];
      end
      default: begin // green between reds
        green = nb[4];
        red   = horz[8:1];
        blue  = vert[8:1];
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: load a pixel when the window stage advances with one,
  // drop valid once the transaction completes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_ctl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.emit) begin
      m_axis_tdata <= {blue, green, red};
      m_axis_tlast <= s1_ctl.frame_end;
    end
  end

`ifndef NO_ASSERTIONS
  // The sample count never runs past the frame.
  a_in_cnt_range: assert property (@(posedge clk) disable iff (rst)
    in_cnt <= CNT_W'(FRAME_SIZE))
    else $error("sample count beyond frame size");

  // Emitting the final pixel restarts both positions.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    load && emit && last_pix |=> (in_cnt == '0) && (out_col == '0) && (out_row == '0))
    else $error("positions not cleared after final pixel");

  // An early drain tick leaves the window stage empty.
  a_early_drain: assert property (@(posedge clk) disable iff (rst)
    in_acc && is_drain && !frame_in |=> !s1_valid)
    else $error("early drain tick entered the pipeline");

  // A blocked window stage keeps its pixel.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_ctl))
    else $error("window stage lost a stalled pixel");

  // The final pixel of a frame is flagged only when the last position leaves.
  a_tlast_src: assert property (@(posedge clk) disable iff (rst)
    load && emit |=> s1_ctl.frame_end == $past(last_pix))
    else $error("frame end flag mismatch");
`endif

endmodule
